>>> hdl/mcr_pkg.sv
// Shared types and constants for the midpoint circle rasteriser.
// No dependencies; imported by every module of the block.
package mcr_pkg;

	localparam int COORD_BITS = 10;
	localparam int OUT_BITS = COORD_BITS + 2;
	localparam int ERR_BITS = COORD_BITS + 3;
	localparam int COLOUR_BITS = 32;

	localparam int PIXELS_PER_STEP = 8;
	localparam int PHASE_BITS = $clog2(PIXELS_PER_STEP);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

	localparam logic CMD_START = 1'b0;
	localparam logic CMD_STEP = 1'b1;

	localparam logic [COLOUR_BITS-1:0] COLOUR_RESET = '1;

	typedef struct packed {
		logic cmd;
		logic [COORD_BITS-1:0] centre_x;
		logic [COORD_BITS-1:0] centre_y;
		logic [COORD_BITS-1:0] radius;
	} item_t;

	typedef struct packed {
		logic signed [OUT_BITS-1:0] pixel_x;
		logic signed [OUT_BITS-1:0] pixel_y;
		logic [COLOUR_BITS-1:0] colour;
		logic last;
		logic done_res;
	} pixel_t;

	typedef struct packed {
		logic done;
		logic [COORD_BITS-1:0] cx;
		logic [COORD_BITS-1:0] cy;
		logic [COORD_BITS-1:0] a;
		logic [COORD_BITS-1:0] b;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

>>> hdl/mcr_front.sv
// Front end: accepts items, keeps the octant point and decision error,
// and queues one job per step item. Depends on mcr_pkg.
module mcr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  mcr_pkg::item_t    item,
	input  mcr_pkg::q_status_t q_status,
	output logic              push,
	output mcr_pkg::job_t     job
);
	import mcr_pkg::*;

	logic [COORD_BITS-1:0] cx_q, cy_q, a_q, b_q;
	logic [ERR_BITS-1:0]   err_q;
	logic                  busy_q;

	logic                  accept;
	logic                  finished;
	logic [ERR_BITS-1:0]   err_inc;
	logic [ERR_BITS-1:0]   err_dec;

	assign item_ready = !q_status.full;
	assign accept     = item_valid && item_ready;
	assign push       = accept && (item.cmd == CMD_STEP);
	assign finished   = !busy_q || (a_q <= b_q);

	assign err_inc = err_q + ERR_BITS'({b_q, 1'b0}) + ERR_BITS'(2);
	assign err_dec = err_inc - (ERR_BITS'({a_q, 1'b0}) - ERR_BITS'(3));

	always_comb begin
		job.done = finished;
		job.cx   = cx_q;
		job.cy   = cy_q;
		job.a    = a_q;
		job.b    = b_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q   <= '0;
			cy_q   <= '0;
			a_q    <= '0;
			b_q    <= '0;
			err_q  <= '0;
			busy_q <= 1'b0;
		end else if (accept) begin
			if (item.cmd == CMD_START) begin
				cx_q   <= item.centre_x;
				cy_q   <= item.centre_y;
				a_q    <= item.radius;
				b_q    <= '0;
				err_q  <= ERR_BITS'(0) - ERR_BITS'(item.radius);
				busy_q <= 1'b1;
			end else if (finished) begin
				busy_q <= 1'b0;
			end else begin
				b_q <= b_q + COORD_BITS'(1);
				if (!err_inc[ERR_BITS-1]) begin
					a_q   <= a_q - COORD_BITS'(1);
					err_q <= err_dec;
				end else begin
					err_q <= err_inc;
				end
			end
		end
	end

endmodule

>>> hdl/mcr_queue.sv
// Short job queue between the front end and the pixel back end.
// Depends on mcr_pkg.
module mcr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  mcr_pkg::job_t      push_job,
	input  logic               pop,
	output mcr_pkg::job_t      head,
	output mcr_pkg::q_status_t status
);
	import mcr_pkg::*;

	job_t                  entries_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [Q_CNT_BITS-1:0] count_q;

	assign head         = entries_q[rd_ptr_q];
	assign status.full  = (count_q == Q_CNT_BITS'(Q_DEPTH));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0
					: wr_ptr_q + Q_PTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0
					: rd_ptr_q + Q_PTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + Q_CNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - Q_CNT_BITS'(1);
			end
		end
	end

endmodule

>>> hdl/mcr_back.sv
// Back end (depends on mcr_pkg): expands each queued job into eight mirrored pixels or
// one done beat, one per cycle while the output is not stalled, into the output register.
module mcr_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mcr_pkg::COLOUR_BITS-1:0]   cfg_wdata,
	input  mcr_pkg::job_t                     head,
	input  mcr_pkg::q_status_t                q_status,
	output logic                              pop,
	output logic                              pixel_valid,
	input  logic                              pixel_ready,
	output mcr_pkg::pixel_t                   pixel
);
	import mcr_pkg::*;

	logic [COLOUR_BITS-1:0] colour_q;
	logic [PHASE_BITS-1:0]  phase_q;
	logic                   pixel_valid_q;
	pixel_t                 pixel_q;

	logic                   advance;
	logic                   final_beat;
	logic [OUT_BITS-1:0]    off_p, off_q, off_r, off_s;
	logic [OUT_BITS-1:0]    dx, dy;
	pixel_t                 next_pixel;

	assign advance    = !q_status.empty && (!pixel_valid_q || pixel_ready);
	assign final_beat = head.done || (phase_q == PHASE_BITS'(PIXELS_PER_STEP - 1));
	assign pop        = advance && final_beat;

	assign off_p = OUT_BITS'(head.a) - OUT_BITS'(1);
	assign off_q = OUT_BITS'(head.b);
	assign off_r = OUT_BITS'(0) - OUT_BITS'(head.a);
	assign off_s = OUT_BITS'(0) - OUT_BITS'(head.b) - OUT_BITS'(1);

	always_comb begin
		case (phase_q)
			3'd0:    begin dx = off_p; dy = off_q; end
			3'd1:    begin dx = off_q; dy = off_p; end
			3'd2:    begin dx = off_r; dy = off_q; end
			3'd3:    begin dx = off_q; dy = off_r; end
			3'd4:    begin dx = off_p; dy = off_s; end
			3'd5:    begin dx = off_s; dy = off_p; end
			3'd6:    begin dx = off_r; dy = off_s; end
			default: begin dx = off_s; dy = off_r; end
		endcase
		if (head.done) begin
			next_pixel.pixel_x = '0;
			next_pixel.pixel_y = '0;
			next_pixel.colour  = '0;
		end else begin
			next_pixel.pixel_x = $signed(OUT_BITS'(head.cx) + dx);
			next_pixel.pixel_y = $signed(OUT_BITS'(head.cy) + dy);
			next_pixel.colour  = colour_q;
		end
		next_pixel.last     = final_beat;
		next_pixel.done_res = head.done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q      <= COLOUR_RESET;
			phase_q       <= '0;
			pixel_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				colour_q <= cfg_wdata;
			end
			if (advance) begin
				pixel_valid_q <= 1'b1;
				phase_q       <= final_beat ? '0 : phase_q + PHASE_BITS'(1);
			end else if (pixel_ready) begin
				pixel_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pixel_q <= next_pixel;
		end
	end

	assign pixel_valid = pixel_valid_q;
	assign pixel       = pixel_q;

`ifndef SYNTH
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid_q && pixel_q.done_res |-> pixel_q.last)
		else $error("done beat without last");

	a_phase_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != '0 |-> !q_status.empty && !head.done)
		else $error("pixel phase advanced without a drawing job");

	a_stall_holds_phase: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid_q && !pixel_ready |=> $stable(phase_q))
		else $error("phase moved while output stalled");

	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> pixel_valid_q && pixel_q.last)
		else $error("job retired without last beat");
`endif

endmodule

>>> hdl/midpoint_circle_rasterizer.sv
// A step item's job is registered in the queue; its beats then go to the output register.
// Throughput: one beat per cycle while the output is not stalled; a drawing step gives
// eight beats of the back end's pixel sequencer, a finishing step one, a start none; the
// two-entry job queue lets new items in meanwhile. Reset (arst_n, asynchronous) clears the
// queue, octant state and output valid, unloads any circle and sets the colour to all ones.
module midpoint_circle_rasterizer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_ready,
	input  mcr_pkg::item_t                  item,
	output logic                            pixel_valid,
	input  logic                            pixel_ready,
	output mcr_pkg::pixel_t                 pixel,
	input  logic                            cfg_we,
	input  logic [mcr_pkg::COLOUR_BITS-1:0] cfg_wdata
);
	import mcr_pkg::*;

	logic      push, pop;
	job_t      push_job, head;
	q_status_t q_status;

	mcr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_status   (q_status),
		.push       (push),
		.job        (push_job)
	);

	mcr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.status   (q_status)
	);

	mcr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.pixel       (pixel)
	);

endmodule
